[rtl/lease_lock_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Lease lock table assertion macros
// Implication helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LEASE_LOCK_TABLE_UNIT_ASSERT_SVH
`define LEASE_LOCK_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LLT_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lease lock table check failed");

// next-cycle implication
`define LLT_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lease lock table check failed");

`endif

[rtl/llt_pkg.sv]
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types and codes of the lease lock table.
// ----------------------------------------------------------------------------
package llt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] FN_ACQUIRE = 3'd0;
	localparam logic [2:0] FN_RELEASE = 3'd1;
	localparam logic [2:0] FN_BEAT    = 3'd2;
	localparam logic [2:0] FN_EXPIRE  = 3'd3;
	localparam logic [2:0] FN_BUMP    = 3'd4;
	localparam logic [2:0] FN_VIEW    = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOCONN   = 3'd1;
	localparam logic [2:0] ST_HELD     = 3'd2;
	localparam logic [2:0] ST_NOTOWNER = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RECLAIM = 1'b1;

	typedef struct packed {
		logic [2:0]       func;
		logic [31:0]      key;
		logic [31:0]      user;
		logic [31:0]      ses;
		logic [47:0]      now;
		logic             done;
		logic [2:0]       st;
		logic             holds;
		logic [31:0]      rkey;
		logic [31:0]      own;
		logic [31:0]      oses;
		logic [31:0]      rev;
		logic [CNT_W-1:0] n;
		logic             pvld;
		logic [31:0]      pkey;
		logic [31:0]      prev;
	} pkt_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] rev;
	} emit_t;

endpackage

[rtl/llt_cell.sv]
// ----------------------------------------------------------------------------
// llt_cell
// One table slot; acts on the command word passing by and hands it on.
// ----------------------------------------------------------------------------
module llt_cell import llt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [31:0] timeout,
	input  logic        reclaim,
	input  logic        in_vld,
	input  pkt_t        in_pkt,
	output logic        out_vld,
	output pkt_t        out_pkt,
	output emit_t       emit
);

	logic        used_q;
	logic [31:0] key_q, owner_q, ses_q, rev_q;
	logic [47:0] beat_q;
	logic        vld_q;
	pkt_t        pkt_q;

	logic        live, match, alloc, lapse, beat_hit, wr;
	logic [47:0] age;
	logic [31:0] owner_d, ses_d, rev_d;
	logic [47:0] beat_d;
	pkt_t        pkt_d;

	assign age  = in_pkt.now - beat_q;
	assign live = (owner_q != '0) && ((in_pkt.now < beat_q) || (age < {16'd0, timeout}));

	always_comb begin
		match    = 1'b0;
		alloc    = 1'b0;
		lapse    = 1'b0;
		beat_hit = 1'b0;
		case (in_pkt.func)
			FN_ACQUIRE, FN_BUMP: begin
				match = used_q && (key_q == in_pkt.key) && !in_pkt.done;
				alloc = !used_q && !in_pkt.done;
			end
			FN_RELEASE, FN_VIEW: begin
				match = used_q && (key_q == in_pkt.key) && !in_pkt.done;
			end
			FN_BEAT: begin
				beat_hit = used_q && !in_pkt.done && (owner_q != '0) && (ses_q == in_pkt.ses);
			end
			FN_EXPIRE: begin
				lapse = used_q && (owner_q != '0) && !live && (in_pkt.n < CNT_W'(MAX_RESULTS));
			end
			default: ;
		endcase
	end

	always_comb begin
		owner_d = owner_q;
		ses_d   = ses_q;
		beat_d  = beat_q;
		rev_d   = rev_q;
		pkt_d   = in_pkt;
		if (alloc) begin
			pkt_d.done = 1'b1;
			pkt_d.st   = ST_OK;
			if (in_pkt.func == FN_ACQUIRE) begin
				owner_d  = in_pkt.user;
				ses_d    = in_pkt.ses;
				beat_d   = in_pkt.now;
				rev_d    = '0;
			end else begin
				owner_d  = '0;
				ses_d    = '0;
				beat_d   = '0;
				rev_d    = 32'd1;
			end
			pkt_d.own  = owner_d;
			pkt_d.oses = ses_d;
			pkt_d.rev  = rev_d;
		end else if (match) begin
			pkt_d.done = 1'b1;
			pkt_d.st   = ST_OK;
			case (in_pkt.func)
				FN_ACQUIRE: begin
					if (live) begin
						if (owner_q == in_pkt.user && (ses_q == in_pkt.ses || reclaim)) begin
							ses_d  = in_pkt.ses;
							beat_d = in_pkt.now;
						end else begin
							pkt_d.st = ST_HELD;
						end
					end else begin
						owner_d = in_pkt.user;
						ses_d   = in_pkt.ses;
						beat_d  = in_pkt.now;
					end
				end
				FN_RELEASE: begin
					if (owner_q == '0 || owner_q != in_pkt.user || ses_q != in_pkt.ses) begin
						pkt_d.st = ST_NOTOWNER;
					end else begin
						owner_d = '0;
						ses_d   = '0;
					end
				end
				FN_BUMP: rev_d = rev_q + 32'd1;
				FN_VIEW: pkt_d.holds = (owner_q == in_pkt.user) && (ses_q == in_pkt.ses) &&
					(in_pkt.user != '0);
				default: ;
			endcase
			pkt_d.own  = owner_d;
			pkt_d.oses = ses_d;
			pkt_d.rev  = rev_d;
		end else if (beat_hit) begin
			beat_d = in_pkt.now;
		end else if (lapse) begin
			owner_d    = '0;
			ses_d      = '0;
			pkt_d.pvld = 1'b1;
			pkt_d.pkey = key_q;
			pkt_d.prev = rev_q;
			pkt_d.n    = in_pkt.n + CNT_W'(1);
		end
	end

	assign emit.valid = in_vld && lapse && in_pkt.pvld;
	assign emit.key   = in_pkt.pkey;
	assign emit.rev   = in_pkt.prev;
	assign wr         = in_vld && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
			if (in_vld && alloc)
				used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			pkt_q <= pkt_d;
		if (wr) begin
			if (alloc)
				key_q <= in_pkt.key;
			owner_q <= owner_d;
			ses_q   <= ses_d;
			beat_q  <= beat_d;
			rev_q   <= rev_d;
		end
	end

	assign out_vld = vld_q;
	assign out_pkt = pkt_q;

endmodule

[rtl/lease_lock_table_unit.sv]
// The only or last result word is registered once the command word leaves the last slot;
// earlier sweep words leave while the walk passes later lapsed slots.
// One command at a time: the command word walks the slot chain one slot per cycle
// while not stalled, and the next command is taken once it leaves the chain.
// A result word waiting on m_tready stalls the walk; with m_tready high, none.
// Reset clears all slots to free and loads timeout 30000, reclaim on.
// ----------------------------------------------------------------------------
// lease_lock_table_unit
// Leased lock table built as a chain of slot cells.
// ----------------------------------------------------------------------------
module lease_lock_table_unit import llt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,  // func, lock_key, user_id, session_id, now_ms
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // status, holds, out_key, out_owner, out_session, out_revision
	output logic         m_tlast,
	input  logic         cfg_wr,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] timeout_q;
	logic        reclaim_q;
	logic        busy_q;
	logic        out_vld_q;
	logic [131:0] out_data_q;
	logic        out_last_q;

	logic        chain_vld [TABLE_DEPTH+1];
	pkt_t        chain_pkt [TABLE_DEPTH+1];
	emit_t       cell_emit [TABLE_DEPTH];
	emit_t       side;
	pkt_t        init_pkt;
	pkt_t        ex;
	logic        ex_vld, ex_emit, need, adv, out_free, accept;
	logic        in_vld_q;
	pkt_t        in_pkt_q;

	logic [2:0]  f_func;
	logic [31:0] f_key, f_user, f_ses;
	logic [47:0] f_now;

	assign f_func = s_tdata[2:0];
	assign f_key  = s_tdata[34:3];
	assign f_user = s_tdata[66:35];
	assign f_ses  = s_tdata[98:67];
	assign f_now  = s_tdata[146:99];

	always_comb begin
		init_pkt      = '0;
		init_pkt.func = f_func;
		init_pkt.key  = f_key;
		init_pkt.user = f_user;
		init_pkt.ses  = f_ses;
		init_pkt.now  = f_now;
		init_pkt.rkey = f_key;
		case (f_func)
			FN_ACQUIRE: begin
				init_pkt.done = (f_key == '0) || (f_user == '0) || (f_ses == '0);
				init_pkt.st   = init_pkt.done ? ST_NOCONN : ST_FULL;
			end
			FN_RELEASE: init_pkt.st = ST_NOTOWNER;
			FN_BEAT: begin
				init_pkt.rkey = '0;
				init_pkt.done = (f_ses == '0);
				init_pkt.st   = init_pkt.done ? ST_NOCONN : ST_OK;
			end
			FN_EXPIRE: init_pkt.st = ST_OK;
			FN_BUMP: begin
				init_pkt.done = (f_key == '0);
				init_pkt.st   = init_pkt.done ? ST_NOCONN : ST_FULL;
			end
			FN_VIEW: init_pkt.done = (f_key == '0);
			default: init_pkt.done = 1'b1;
		endcase
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign out_free = !out_vld_q || m_tready;

	assign chain_vld[0] = in_vld_q;
	assign chain_pkt[0] = in_pkt_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		llt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.timeout (timeout_q),
			.reclaim (reclaim_q),
			.in_vld  (chain_vld[g]),
			.in_pkt  (chain_pkt[g]),
			.out_vld (chain_vld[g+1]),
			.out_pkt (chain_pkt[g+1]),
			.emit    (cell_emit[g])
		);
	end

	// at most one cell holds the word, so an OR merge is enough
	always_comb begin
		side = '0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			side = side | cell_emit[i];
	end

	assign ex     = chain_pkt[TABLE_DEPTH];
	assign ex_vld = chain_vld[TABLE_DEPTH];

	always_comb begin
		case (ex.func)
			FN_ACQUIRE, FN_RELEASE, FN_BEAT, FN_BUMP, FN_VIEW: ex_emit = 1'b1;
			FN_EXPIRE: ex_emit = ex.pvld;
			default: ex_emit = 1'b0;
		endcase
	end

	assign need = side.valid || (ex_vld && ex_emit);
	assign adv  = !need || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 32'd30000;
			reclaim_q  <= 1'b1;
			busy_q     <= 1'b0;
			in_vld_q   <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_RECLAIM: reclaim_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				busy_q   <= 1'b1;
				in_vld_q <= 1'b1;
			end else if (adv) begin
				in_vld_q <= 1'b0;
				if (ex_vld)
					busy_q <= 1'b0;
			end
			if (adv && need)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_pkt_q <= init_pkt;
		if (adv && side.valid) begin
			out_data_q <= {side.rev, 32'd0, 32'd0, side.key, 1'b0, ST_OK};
			out_last_q <= 1'b0;
		end else if (adv && ex_vld && ex_emit) begin
			if (ex.func == FN_EXPIRE)
				out_data_q <= {ex.prev, 32'd0, 32'd0, ex.pkey, 1'b0, ST_OK};
			else
				out_data_q <= {ex.rev, ex.oses, ex.own, ex.rkey, ex.holds, ex.st};
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_data_q};
	assign m_tlast  = out_last_q;

endmodule

[rtl/llt_checker.sv]
// ----------------------------------------------------------------------------
// llt_checker
// Port-level checks of the lease lock table, bound to the top level.
// ----------------------------------------------------------------------------
`include "lease_lock_table_unit_assert.svh"

module llt_checker import llt_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic         m_tlast
);

	`LLT_AST_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`LLT_AST_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`LLT_AST_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= ST_FULL)
	`LLT_AST_NOW(a_holds_ok, m_tvalid && m_tdata[3], m_tdata[2:0] == ST_OK && m_tlast)

endmodule

bind lease_lock_table_unit llt_checker u_llt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[dv/lease_lock_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// lease_lock_table_unit_tb
// Drives lock commands (acquire, release, heartbeat, sweep, bump, view) into
// the table under several timeout and reclaim settings, predicts every result
// word from a private copy of the table and compares field by field.
// ----------------------------------------------------------------------------
module lease_lock_table_unit_tb;
	import llt_pkg::*;

	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;
	localparam int DRAIN_CYC = TABLE_DEPTH + 24;
	localparam int WDOG_LIMIT = 3000;
	localparam logic [47:0] MAX_NOW = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  st;
		logic        holds;
		logic [31:0] key;
		logic [31:0] own;
		logic [31:0] ses;
		logic [31:0] rev;
		logic        last;
	} word_t;

	typedef struct {
		logic [2:0]  func;
		logic [31:0] key;
		logic [31:0] user;
		logic [31:0] ses;
		logic [47:0] now;
		bit          typed;
		word_t       want;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         m_tlast;
	logic         cfg_wr = 1'b0;
	logic         cfg_index = 1'b0;
	logic [31:0]  cfg_data = '0;

	lease_lock_table_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the table
	bit          slot_used [TABLE_DEPTH];
	logic [31:0] slot_key  [TABLE_DEPTH];
	logic [31:0] slot_own  [TABLE_DEPTH];
	logic [31:0] slot_ses  [TABLE_DEPTH];
	logic [47:0] slot_beat [TABLE_DEPTH];
	logic [31:0] slot_rev  [TABLE_DEPTH];
	logic [31:0] timeout_ms = 32'd30000;
	logic        reclaim = 1'b1;

	word_t pending_words[$];
	int    n_err = 0, n_words = 0, n_items = 0, n_full = 0, n_swept = 0;
	bit    quiet = 1'b0;
	int    idle_cyc = 0;

	function automatic void add_word(word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic bit lease_live(int i, logic [47:0] now);
		if (slot_own[i] == 0) return 1'b0;
		if (now < slot_beat[i]) return 1'b1;
		return (now - slot_beat[i]) < {16'd0, timeout_ms};
	endfunction

	function automatic int slot_of(logic [31:0] key);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_used[i] && slot_key[i] == key) return i;
		return -1;
	endfunction

	function automatic int slot_new(logic [31:0] key);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (!slot_used[i]) begin
				slot_used[i] = 1'b1;
				slot_key[i] = key;
				slot_own[i] = '0;
				slot_ses[i] = '0;
				slot_beat[i] = '0;
				slot_rev[i] = '0;
				return i;
			end
		return -1;
	endfunction

	function automatic word_t slot_word(logic [2:0] st, logic h, logic [31:0] key, int i);
		word_t w;
		w = '{st: st, holds: h, key: key, own: '0, ses: '0, rev: '0, last: 1'b1};
		if (i >= 0) begin
			w.own = slot_own[i];
			w.ses = slot_ses[i];
			w.rev = slot_rev[i];
		end
		return w;
	endfunction

	// applies one command to the table copy and queues the words it yields
	function automatic int lock_table_apply(logic [2:0] func, logic [31:0] key,
			logic [31:0] user, logic [31:0] ses, logic [47:0] now);
		int i, n;
		n = 0;
		case (func)
			FN_ACQUIRE: begin
				if (key == 0 || user == 0 || ses == 0) begin
					add_word(slot_word(ST_NOCONN, 1'b0, key, -1));
					return 1;
				end
				i = slot_of(key);
				if (i < 0) i = slot_new(key);
				if (i < 0) begin
					n_full++;
					add_word(slot_word(ST_FULL, 1'b0, key, -1));
					return 1;
				end
				if (lease_live(i, now)) begin
					if (slot_own[i] == user && (slot_ses[i] == ses || reclaim)) begin
						slot_ses[i] = ses;
						slot_beat[i] = now;
						add_word(slot_word(ST_OK, 1'b0, key, i));
					end else
						add_word(slot_word(ST_HELD, 1'b0, key, i));
					return 1;
				end
				slot_own[i] = user;
				slot_ses[i] = ses;
				slot_beat[i] = now;
				add_word(slot_word(ST_OK, 1'b0, key, i));
				return 1;
			end
			FN_RELEASE: begin
				i = slot_of(key);
				if (i < 0 || slot_own[i] == 0 || slot_own[i] != user || slot_ses[i] != ses) begin
					add_word(slot_word(ST_NOTOWNER, 1'b0, key, i));
					return 1;
				end
				slot_own[i] = '0;
				slot_ses[i] = '0;
				add_word(slot_word(ST_OK, 1'b0, key, i));
				return 1;
			end
			FN_BEAT: begin
				if (ses == 0) begin
					add_word(slot_word(ST_NOCONN, 1'b0, '0, -1));
					return 1;
				end
				for (i = 0; i < TABLE_DEPTH; i++)
					if (slot_used[i] && slot_own[i] != 0 && slot_ses[i] == ses)
						slot_beat[i] = now;
				add_word(slot_word(ST_OK, 1'b0, '0, -1));
				return 1;
			end
			FN_EXPIRE: begin
				for (i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++) begin
					if (!slot_used[i] || slot_own[i] == 0 || lease_live(i, now)) continue;
					slot_own[i] = '0;
					slot_ses[i] = '0;
					add_word('{st: ST_OK, holds: 1'b0, key: slot_key[i],
						own: '0, ses: '0, rev: slot_rev[i], last: 1'b0});
					n++;
				end
				if (n > 0) pending_words[$].last = 1'b1;
				n_swept += n;
				return n;
			end
			FN_BUMP: begin
				if (key == 0) begin
					add_word(slot_word(ST_NOCONN, 1'b0, key, -1));
					return 1;
				end
				i = slot_of(key);
				if (i < 0) i = slot_new(key);
				if (i < 0) begin
					n_full++;
					add_word(slot_word(ST_FULL, 1'b0, key, -1));
					return 1;
				end
				slot_rev[i] = slot_rev[i] + 32'd1;
				add_word(slot_word(ST_OK, 1'b0, key, i));
				return 1;
			end
			FN_VIEW: begin
				i = (key == 0) ? -1 : slot_of(key);
				if (i < 0) begin
					add_word(slot_word(ST_OK, 1'b0, key, -1));
					return 1;
				end
				add_word(slot_word(ST_OK,
					slot_own[i] == user && slot_ses[i] == ses && user != 0, key, i));
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		n_err++;
	endtask

	// result side
	always @(posedge clk) begin
		word_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{st: m_tdata[2:0], holds: m_tdata[3], key: m_tdata[35:4],
				own: m_tdata[67:36], ses: m_tdata[99:68], rev: m_tdata[131:100],
				last: m_tlast};
			n_words++;
			if (pending_words.size() == 0)
				report_mismatch("unexpected word, key", got.key, '0);
			else begin
				want = pending_words.pop_front();
				if (got.st != want.st) report_mismatch("status", 32'(got.st), 32'(want.st));
				if (got.holds != want.holds)
					report_mismatch("holds", 32'(got.holds), 32'(want.holds));
				if (got.key != want.key) report_mismatch("key", got.key, want.key);
				if (got.own != want.own) report_mismatch("owner", got.own, want.own);
				if (got.ses != want.ses) report_mismatch("session", got.ses, want.ses);
				if (got.rev != want.rev) report_mismatch("revision", got.rev, want.rev);
				if (got.last != want.last)
					report_mismatch("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
		else idle_cyc++;
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("watchdog expired, %0d words outstanding", pending_words.size());
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stalls
	initial begin
		forever begin
			if (quiet || $urandom_range(0, 2) == 0) begin
				@(negedge clk) m_tready = 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end else begin
				@(negedge clk) m_tready = 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end
		end
	end

	task automatic send_cmd(logic [2:0] func, logic [31:0] key, logic [31:0] user,
			logic [31:0] ses, logic [47:0] now, bit typed, word_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk) s_tvalid = 1'b0;
			repeat ($urandom_range(1, 13) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {5'd0, now, ses, user, key, func};
		do @(posedge clk); while (!s_tready);
		if (lock_table_apply(func, key, user, ses, now) == 1 && typed)
			pending_words[$] = want;
		if (func != FN_SPARE_A && func != FN_SPARE_B) n_items++;
		@(negedge clk) s_tvalid = 1'b0;
	endtask

	task automatic settle_and_config(logic [31:0] tmo, logic rcl);
		wait (pending_words.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		cfg_wr = 1'b1;
		cfg_index = REG_TIMEOUT;
		cfg_data = tmo;
		@(negedge clk);
		cfg_index = REG_RECLAIM;
		cfg_data = {31'd0, rcl};
		@(negedge clk);
		cfg_wr = 1'b0;
		timeout_ms = tmo;
		reclaim = rcl;
	endtask

	function automatic word_t ww(logic [2:0] st, logic h, logic [31:0] k, logic [31:0] o,
			logic [31:0] s, logic [31:0] r);
		return '{st: st, holds: h, key: k, own: o, ses: s, rev: r, last: 1'b1};
	endfunction

	initial begin
		row_t rows[$];
		logic [31:0] key_pool[24];
		logic [31:0] tmo_set[5];
		logic        rcl_set[5];
		logic [47:0] t_now;
		logic [31:0] k, u, s;
		logic [2:0]  f;
		int          r;
		int unsigned lim;

		for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
		foreach (key_pool[i]) key_pool[i] = (i < 8) ? i + 1 : $urandom;
		key_pool[23] = 32'hFFFF_FFFF;
		tmo_set = '{32'd30000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd500};
		rcl_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		rows = '{
			'{FN_VIEW,    5, 1, 1, 0, 1, ww(ST_OK, 0, 5, 0, 0, 0)},
			'{FN_ACQUIRE, 0, 1, 1, 0, 1, ww(ST_NOCONN, 0, 0, 0, 0, 0)},
			'{FN_ACQUIRE, 1, 1, 0, 10, 1, ww(ST_NOCONN, 0, 1, 0, 0, 0)},
			'{FN_ACQUIRE, 1, 1, 1, 10, 1, ww(ST_OK, 0, 1, 1, 1, 0)},
			'{FN_ACQUIRE, 1, 2, 2, 20, 1, ww(ST_HELD, 0, 1, 1, 1, 0)},
			'{FN_ACQUIRE, 1, 1, 9, 30, 1, ww(ST_OK, 0, 1, 1, 9, 0)},
			'{FN_RELEASE, 1, 1, 1, 40, 1, ww(ST_NOTOWNER, 0, 1, 1, 9, 0)},
			'{FN_VIEW,    1, 1, 9, 40, 1, ww(ST_OK, 1, 1, 1, 9, 0)},
			'{FN_BEAT,    0, 0, 0, 50, 1, ww(ST_NOCONN, 0, 0, 0, 0, 0)},
			'{FN_BEAT,    0, 0, 9, 100, 1, ww(ST_OK, 0, 0, 0, 0, 0)},
			'{FN_BUMP,    0, 0, 0, 100, 1, ww(ST_NOCONN, 0, 0, 0, 0, 0)},
			'{FN_BUMP,    2, 0, 0, 100, 1, ww(ST_OK, 0, 2, 0, 0, 1)},
			'{FN_EXPIRE,  0, 0, 0, 0, 0, '0},
			'{FN_EXPIRE,  0, 0, 0, 200000, 0, '0},
			'{FN_RELEASE, 3, 1, 1, 200000, 1, ww(ST_NOTOWNER, 0, 3, 0, 0, 0)},
			'{FN_SPARE_A, 1, 1, 1, 0, 0, '0},
			'{FN_SPARE_B, 1, 1, 1, 0, 0, '0},
			'{FN_ACQUIRE, '1, '1, '1, MAX_NOW, 1, ww(ST_OK, 0, '1, '1, '1, 0)},
			'{FN_VIEW,    '1, '1, '1, MAX_NOW, 0, '0},
			'{FN_RELEASE, '1, '1, '1, MAX_NOW, 1, ww(ST_OK, 0, '1, 0, 0, 0)},
			'{FN_BUMP,    '1, 0, 0, MAX_NOW, 1, ww(ST_OK, 0, '1, 0, 0, 1)}
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_cmd(rows[i].func, rows[i].key, rows[i].user, rows[i].ses, rows[i].now,
				rows[i].typed, rows[i].want);

		t_now = 48'd1000;
		for (int ph = 0; ph < 5; ph++) begin
			settle_and_config(tmo_set[ph], rcl_set[ph]);
			quiet = (ph == 4);
			lim = (timeout_ms > 32'd1000000) ? 32'd1000000 : 32'd2 * timeout_ms + 32'd2;
			for (int n = 0; n < 64; n++) begin
				r = $urandom_range(0, 99);
				if (r < 40) t_now += 48'($urandom_range(0, 3));
				else if (r < 80) t_now += 48'($urandom_range(0, lim));
				else if (r < 90) t_now -= (t_now > 50) ? 48'($urandom_range(0, 50)) : 48'd0;
				else if (r < 96) t_now += {16'd0, $urandom};
				else t_now = {16'($urandom), $urandom};

				r = $urandom_range(0, 99);
				if (r < 30) f = FN_ACQUIRE;
				else if (r < 48) f = FN_RELEASE;
				else if (r < 60) f = FN_BEAT;
				else if (r < 72) f = FN_EXPIRE;
				else if (r < 82) f = FN_BUMP;
				else if (r < 97) f = FN_VIEW;
				else f = ($urandom_range(0, 1)) ? FN_SPARE_A : FN_SPARE_B;

				r = $urandom_range(0, 99);
				k = (r < 5) ? 32'd0 : (r < 10) ? $urandom : key_pool[$urandom_range(0, 23)];
				r = $urandom_range(0, 99);
				u = (r < 5) ? 32'd0 : (r < 10) ? $urandom : $urandom_range(1, 3);
				r = $urandom_range(0, 99);
				s = (r < 5) ? 32'd0 : (r < 10) ? $urandom : $urandom_range(1, 4);
				send_cmd(f, k, u, s, t_now, 1'b0, '0);
			end
		end

		wait (pending_words.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		$display("%0d commands, %0d result words, %0d leases swept, %0d table-full replies",
			n_items, n_words, n_swept, n_full);
		$display("five timeout/reclaim settings including zero and maximum timeout");
		if (n_err == 0 && pending_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/llt_pkg.sv
rtl/llt_cell.sv
rtl/lease_lock_table_unit.sv
rtl/llt_checker.sv
dv/lease_lock_table_unit_tb.sv
